@@ sv/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define SRX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define SRX_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/srx_pkg.sv @@
`default_nettype none

package srx_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_BYTES = 28;
  localparam int unsigned NUM_CHANNELS  = 16;
  localparam int unsigned PAIR_CHANNELS = 14;
  localparam int unsigned PAY_AW        = $clog2(PAYLOAD_BYTES);

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned VAL_W   = 13;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CLAMP_MAX = 2048;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_FIRST  = 2'd0,
    CFG_START_SECOND = 2'd1,
    CFG_CENTER       = 2'd2,
    CFG_CLAMP        = 2'd3
  } cfg_reg_e;

  // front parser phases
  typedef enum logic [2:0] {
    PH_HUNT       = 3'd0,
    PH_GOT_FIRST  = 3'd1,
    PH_DATA       = 3'd2,
    PH_CHECK_LOW  = 3'd3,
    PH_CHECK_HIGH = 3'd4
  } phase_e;

  // back sequencer states
  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_ADDR = 3'd1,
    BK_DATA = 3'd2,
    BK_CALC = 3'd3,
    BK_PUSH = 3'd4
  } back_state_e;

  // payload store write from the front
  typedef struct packed {
    logic              we;
    logic [PAY_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } pay_wr_t;

  // one decoded channel
  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } result_t;

  // job queue handshake between front and back
  typedef struct packed {
    logic             valid;
    logic             full;
    logic [CNT_W-1:0] count;
  } job_status_t;

endpackage

`default_nettype wire

@@ sv/srx_front.sv @@
`default_nettype none

module srx_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [srx_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic [srx_pkg::BYTE_W-1:0] start_first_i,
  input  wire logic [srx_pkg::BYTE_W-1:0] start_second_i,
  input  wire srx_pkg::job_status_t       job_status_i,
  output srx_pkg::pay_wr_t                pay_wr_o,
  output logic                            job_push_o,
  output logic [srx_pkg::CNT_W-1:0]       job_count_o
);
  import srx_pkg::*;

  phase_e              phase_q, phase_d;
  logic [PAY_AW-1:0]   pos_q, pos_d;
  logic [15:0]         sum_q, sum_d;
  logic [BYTE_W-1:0]   chk_lo_q, chk_lo_d;
  logic [CNT_W-1:0]    good_q, good_d;
  logic                accept;
  logic                sum_ok;
  logic [15:0]         sum_minus;

  assign accept    = push_i && !full_o;
  assign sum_minus = sum_q - {8'd0, rx_byte_i};
  assign sum_ok    = (sum_q[7:0] == chk_lo_q) && (sum_q[15:8] == rx_byte_i);

  // next state and parser registers
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    chk_lo_d = chk_lo_q;
    good_d   = good_q;
    if (accept) begin
      case (phase_q)
        PH_GOT_FIRST: begin
          if (rx_byte_i == start_second_i) begin
            sum_d   = sum_minus;
            phase_d = PH_DATA;
            pos_d   = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_DATA: begin
          sum_d = sum_minus;
          if (pos_q == PAY_AW'(PAYLOAD_BYTES - 1)) begin
            phase_d = PH_CHECK_LOW;
          end else begin
            pos_d = pos_q + PAY_AW'(1);
          end
        end
        PH_CHECK_LOW: begin
          chk_lo_d = rx_byte_i;
          phase_d  = PH_CHECK_HIGH;
        end
        PH_CHECK_HIGH: begin
          phase_d = PH_HUNT;
          if (sum_ok) begin
            good_d = good_q + CNT_W'(1);
          end
        end
        default: begin
          // hunting, unused codes included
          if (rx_byte_i == start_first_i) begin
            sum_d   = 16'hFFFF - {8'd0, rx_byte_i};
            phase_d = PH_GOT_FIRST;
          end else begin
            sum_d   = 16'hFFFF;
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  // outputs: stall payload while the back still reads the last frame
  always_comb begin
    full_o        = 1'b0;
    pay_wr_o.we   = 1'b0;
    pay_wr_o.addr = pos_q;
    pay_wr_o.data = rx_byte_i;
    job_push_o    = 1'b0;
    job_count_o   = good_q + CNT_W'(1);
    case (phase_q)
      PH_DATA: begin
        full_o      = job_status_i.valid;
        pay_wr_o.we = push_i && !job_status_i.valid;
      end
      PH_CHECK_HIGH: begin
        full_o     = job_status_i.full;
        job_push_o = push_i && !job_status_i.full && sum_ok;
      end
      default: begin
        full_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      pos_q    <= '0;
      sum_q    <= 16'hFFFF;
      chk_lo_q <= '0;
      good_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      chk_lo_q <= chk_lo_d;
      good_q   <= good_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/srx_jobq.sv @@
`default_nettype none

module srx_jobq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire logic [srx_pkg::CNT_W-1:0] count_i,
  input  wire logic                      pop_i,
  output srx_pkg::job_status_t           status_o
);
  import srx_pkg::*;

  logic [CNT_W-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;
  logic             do_push, do_pop;

  assign do_push = push_i && (fill_q != 2'd2);
  assign do_pop  = pop_i && (fill_q != 2'd0);

  assign status_o.valid = (fill_q != 2'd0);
  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.count = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= count_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/srx_back.sv @@
`default_nettype none

module srx_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire srx_pkg::pay_wr_t          pay_wr_i,
  input  wire srx_pkg::job_status_t      job_status_i,
  output logic                           job_pop_o,
  input  wire logic [srx_pkg::RAW_W-1:0] center_i,
  input  wire logic [srx_pkg::RAW_W-1:0] clamp_i,
  input  wire logic                      res_full_i,
  output logic                           res_push_o,
  output srx_pkg::result_t               res_o
);
  import srx_pkg::*;

  logic [BYTE_W-1:0]       pay_mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0]       rd_data_q;
  back_state_e             state_q, state_d;
  logic [IDX_W-1:0]        ch_q;
  logic [1:0]              sub_q;
  logic [RAW_W-1:0]        raw_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    rd_en;
  logic [PAY_AW-1:0]       rd_addr;
  logic                    is_pair;
  logic                    last_sub;
  logic                    last_ch;
  logic [1:0]              grp;
  logic signed [13:0]      diff;
  logic signed [13:0]      lim;
  logic signed [13:0]      clamped;

  assign is_pair  = (ch_q < IDX_W'(PAIR_CHANNELS));
  assign last_sub = is_pair ? (sub_q == 2'd1) : (sub_q == 2'd2);
  assign last_ch  = (ch_q == IDX_W'(NUM_CHANNELS - 1));
  assign grp      = 2'(ch_q - IDX_W'(PAIR_CHANNELS));

  // byte address: pair channels read 2c and 2c+1, nibble channels 6k+1, 6k+3, 6k+5
  always_comb begin
    if (is_pair) begin
      rd_addr = {ch_q[PAY_AW-2:0], sub_q[0]};
    end else begin
      rd_addr = PAY_AW'({grp, 2'b00}) + PAY_AW'({grp, 1'b0}) + PAY_AW'({sub_q, 1'b1});
    end
  end

  // center and clamp
  always_comb begin
    diff = $signed({2'b00, raw_q}) - $signed({2'b00, center_i});
    if (clamp_i > RAW_W'(CLAMP_MAX)) begin
      lim = 14'sd2048;
    end else begin
      lim = $signed({2'b00, clamp_i});
    end
    if (diff > lim) begin
      clamped = lim;
    end else if (diff < -lim) begin
      clamped = -lim;
    end else begin
      clamped = diff;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_status_i.valid) begin
          state_d = BK_ADDR;
        end
      end
      BK_ADDR: begin
        state_d = BK_DATA;
      end
      BK_DATA: begin
        state_d = last_sub ? BK_CALC : BK_ADDR;
      end
      BK_CALC: begin
        state_d = BK_PUSH;
      end
      BK_PUSH: begin
        if (!res_full_i) begin
          state_d = last_ch ? BK_IDLE : BK_ADDR;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    rd_en      = 1'b0;
    res_push_o = 1'b0;
    job_pop_o  = 1'b0;
    case (state_q)
      BK_ADDR: begin
        rd_en = 1'b1;
      end
      BK_PUSH: begin
        res_push_o = !res_full_i;
        job_pop_o  = !res_full_i && last_ch;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign res_o.index = ch_q;
  assign res_o.value = val_q;
  assign res_o.count = job_status_i.count;
  assign res_o.last  = last_ch;

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ch_q    <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_IDLE: begin
          ch_q  <= '0;
          sub_q <= '0;
        end
        BK_DATA: begin
          sub_q <= last_sub ? 2'd0 : sub_q + 2'd1;
        end
        BK_PUSH: begin
          if (!res_full_i) begin
            ch_q <= ch_q + IDX_W'(1);
          end
        end
        default: begin
          sub_q <= sub_q;
        end
      endcase
    end
  end

  // assemble raw value and register the centered result
  always_ff @(posedge clk_i) begin
    if (state_q == BK_DATA) begin
      if (is_pair) begin
        if (sub_q == 2'd0) begin
          raw_q[7:0] <= rd_data_q;
        end else begin
          raw_q[11:8] <= rd_data_q[3:0];
        end
      end else begin
        case (sub_q)
          2'd0:    raw_q[3:0]  <= rd_data_q[7:4];
          2'd1:    raw_q[7:4]  <= rd_data_q[7:4];
          default: raw_q[11:8] <= rd_data_q[7:4];
        endcase
      end
    end
    if (state_q == BK_CALC) begin
      val_q <= VAL_W'(clamped);
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (pay_wr_i.we) begin
      pay_mem[pay_wr_i.addr] <= pay_wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= pay_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/srx_outq.sv @@
`default_nettype none

module srx_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire srx_pkg::result_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output srx_pkg::result_t      data_o
);
  import srx_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/servo_frame_receiver_top.sv @@
// Frame parser takes one byte per cycle while full is low; payload bytes of a new frame wait
// while the back end still reads the previous frame from the payload store, and the second
// check byte waits while the job queue is full.
// Back end reads the payload through the single store read port, an address state then a
// data state per byte, then computes and pushes each channel of a 16-channel frame in turn.
// Reset (async, active low): control and config registers to defaults, parser hunting,
// queues empty; the payload store is not cleared.
`default_nettype none

module servo_frame_receiver_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // byte input
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [srx_pkg::BYTE_W-1:0]  rx_byte_i,
  // results
  output logic                             empty,
  input  wire logic                        pop,
  output logic [srx_pkg::IDX_W-1:0]        channel_index_o,
  output logic signed [srx_pkg::VAL_W-1:0] channel_value_o,
  output logic [srx_pkg::CNT_W-1:0]        frame_count_o,
  output logic                             last_channel_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import srx_pkg::*;

  logic [BYTE_W-1:0] start_first_q;
  logic [BYTE_W-1:0] start_second_q;
  logic [RAW_W-1:0]  center_q;
  logic [RAW_W-1:0]  clamp_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  pay_wr_t           pay_wr;
  job_status_t       job_status;
  logic              job_push;
  logic [CNT_W-1:0]  job_count;
  logic              job_pop;
  logic              res_push;
  logic              res_full;
  result_t           res_in;
  result_t           res_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= 8'h20;
      start_second_q <= 8'h40;
      center_q       <= 12'd1500;
      clamp_q        <= 12'd512;
    end else if (cfg_wr) begin
      case (cfg_sel)
        CFG_START_FIRST:  start_first_q  <= pwdata[BYTE_W-1:0];
        CFG_START_SECOND: start_second_q <= pwdata[BYTE_W-1:0];
        CFG_CENTER:       center_q       <= pwdata[RAW_W-1:0];
        CFG_CLAMP:        clamp_q        <= pwdata[RAW_W-1:0];
        default:          clamp_q        <= clamp_q;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_sel)
      CFG_START_FIRST:  prdata = {24'd0, start_first_q};
      CFG_START_SECOND: prdata = {24'd0, start_second_q};
      CFG_CENTER:       prdata = {20'd0, center_q};
      CFG_CLAMP:        prdata = {20'd0, clamp_q};
      default:          prdata = '0;
    endcase
  end

  srx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .rx_byte_i      (rx_byte_i),
    .start_first_i  (start_first_q),
    .start_second_i (start_second_q),
    .job_status_i   (job_status),
    .pay_wr_o       (pay_wr),
    .job_push_o     (job_push),
    .job_count_o    (job_count)
  );

  srx_jobq u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (job_push),
    .count_i  (job_count),
    .pop_i    (job_pop),
    .status_o (job_status)
  );

  srx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pay_wr_i     (pay_wr),
    .job_status_i (job_status),
    .job_pop_o    (job_pop),
    .center_i     (center_q),
    .clamp_i      (clamp_q),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  srx_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign channel_index_o = res_out.index;
  assign channel_value_o = res_out.value;
  assign frame_count_o   = res_out.count;
  assign last_channel_o  = res_out.last;

endmodule

`default_nettype wire

@@ sv/srx_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module srx_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [4:0]  channel_index_o,
  input wire logic [12:0] channel_value_o,
  input wire logic [15:0] frame_count_o,
  input wire logic        last_channel_o
);
  import srx_pkg::*;

  // no result can be waiting right after a reset cycle
  `SRX_ASSERT_ANY(a_empty_in_reset, !rst_ni |=> empty, "result shown after reset")

  // a waiting result that is not taken holds its value, index and count
  `SRX_ASSERT_RST(a_result_holds, !empty && !pop |=> !empty && $stable(channel_value_o) && $stable(channel_index_o) && $stable(frame_count_o), "stalled result changed")

  // values stay inside the widest clamp
  `SRX_ASSERT_RST(a_value_range, !empty |-> ($signed(channel_value_o) <= 13'sd2048) && ($signed(channel_value_o) >= -13'sd2048), "channel value beyond clamp range")

  // the last flag marks the final channel only
  `SRX_ASSERT_RST(a_last_index, !empty && last_channel_o |-> channel_index_o == IDX_W'(NUM_CHANNELS - 1), "last flag on wrong channel")

endmodule

bind servo_frame_receiver_top srx_checker u_srx_checker (.*);

`default_nettype wire
